// ===== src/pattern_step_sequencer_macros.svh =====
// Assertion macros for the pattern step sequencer.
`ifndef PATTERN_STEP_SEQUENCER_MACROS_SVH
`define PATTERN_STEP_SEQUENCER_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define PSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pattern_step_sequencer: assertion failed");
// Check a property on every clock edge, reset included.
`define PSS_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pattern_step_sequencer: reset assertion failed");
`else
`define PSS_ASSERT(label, prop)
`define PSS_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== src/pss_pkg.sv =====
// Shared types, constants and helpers of the pattern step sequencer.
package pss_pkg;

  localparam int ROWS_DEFAULT     = 32;
  localparam int CHANNELS_DEFAULT = 4;

  localparam int COMMAND_W  = 4;
  localparam int ROW_W      = 5;
  localparam int CHANNEL_W  = 2;
  localparam int NOTE_W     = 5;
  localparam int INSTR_W    = 2;
  localparam int PITCH_W    = 7;
  localparam int LEVEL_W    = 3;
  localparam int TICK_W     = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  localparam int APB_ADDR_W = 2;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-1:0] ADDR_TICKS_PER_ROW = 2'd0;

  localparam logic [TICK_W-1:0]  TICKS_PER_ROW_RESET = 8'd6;
  localparam logic [TICK_W-1:0]  TICK_SAT            = 8'hFF;
  localparam logic [NOTE_W-1:0]  NOTE_MAX            = 5'd24;
  localparam logic [NOTE_W-1:0]  NOTE_OCTAVE         = 5'd12;
  localparam int                 NOISE_CHANNEL       = 3;
  localparam logic [PITCH_W-1:0] NOISE_PITCH_BASE    = 7'd36;
  localparam logic [PITCH_W-1:0] TONE_PITCH_BASE     = 7'd59;
  localparam logic [LEVEL_W-1:0] NOISE_LEVEL         = 3'd4;
  localparam logic [LEVEL_W-1:0] TONE_LEVEL          = 3'd6;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_TICK        = 4'd0,
    CMD_UP          = 4'd1,
    CMD_DOWN        = 4'd2,
    CMD_LEFT        = 4'd3,
    CMD_RIGHT       = 4'd4,
    CMD_NOTE_DOWN   = 4'd5,
    CMD_NOTE_UP     = 4'd6,
    CMD_NEXT_INSTR  = 4'd7,
    CMD_CLEAR       = 4'd8,
    CMD_PLAY_TOGGLE = 4'd9,
    CMD_WRITE_CELL  = 4'd10,
    CMD_NONE        = 4'd11
  } cmd_t;

  typedef struct packed {
    logic [INSTR_W-1:0] instrument;
    logic [NOTE_W-1:0]  note;
  } cell_t;

  typedef struct packed {
    logic [1:0]           pad;
    logic [INSTR_W-1:0]   instrument;
    logic [NOTE_W-1:0]    note;
    logic [CHANNEL_W-1:0] channel;
    logic [ROW_W-1:0]     row;
  } in_data_t;

  typedef struct packed {
    logic [6:0]           pad;
    logic [INSTR_W-1:0]   cell_instrument;
    logic [NOTE_W-1:0]    cell_note;
    logic [CHANNEL_W-1:0] cursor_channel;
    logic [ROW_W-1:0]     cursor_row;
    logic [ROW_W-1:0]     play_row;
    logic                 playing;
    logic                 open_channel;
    logic                 silence;
    logic [LEVEL_W-1:0]   level;
    logic [PITCH_W-1:0]   pitch;
    logic                 note_on;
  } out_data_t;

  typedef struct packed {
    logic clr_wr;
    logic take;
    logic exec;
    logic scan_rd;
    logic scan_chk;
    logic fin_rd;
    logic fin_load;
  } dp_ctl_t;

  typedef struct packed {
    logic clr_last;
    logic need_scan;
    logic scan_hit;
    logic scan_last;
  } dp_sts_t;

  function automatic logic [NOTE_W-1:0] note_mod12(input logic [NOTE_W-1:0] n);
    logic [NOTE_W-1:0] r;
    if (n >= 2 * NOTE_OCTAVE) begin
      r = n - 2 * NOTE_OCTAVE;
    end else if (n >= NOTE_OCTAVE) begin
      r = n - NOTE_OCTAVE;
    end else begin
      r = n;
    end
    return r;
  endfunction

endpackage

// ===== src/pss_ctrl.sv =====
// Sequencing state machine of the pattern step sequencer.
module pss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output pss_pkg::dp_ctl_t ctl,
  input  pss_pkg::dp_sts_t sts
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FIN_RD,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_CLEAR: begin
        ctl.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          ctl.take   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = sts.need_scan ? ST_SCAN_RD : ST_FIN_RD;
      end
      ST_SCAN_RD: begin
        ctl.scan_rd = 1'b1;
        state_next  = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        ctl.scan_chk = 1'b1;
        state_next   = (sts.scan_hit || sts.scan_last) ? ST_FIN_RD : ST_SCAN_RD;
      end
      ST_FIN_RD: begin
        ctl.fin_rd = 1'b1;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!m_tvalid || m_tready) begin
          ctl.fin_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.fin_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/pss_datapath.sv =====
// Pattern memory, cursor, playback registers and result register of the sequencer.
module pss_datapath #(
  parameter int ROWS     = pss_pkg::ROWS_DEFAULT,
  parameter int CHANNELS = pss_pkg::CHANNELS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pss_pkg::dp_ctl_t                  ctl,
  output pss_pkg::dp_sts_t                  sts,
  input  logic [pss_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [pss_pkg::COMMAND_W-1:0]     s_tuser,
  input  logic [pss_pkg::TICK_W-1:0]        ticks_per_row,
  output logic [pss_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_CH  = CW'(CHANNELS - 1);

  pss_pkg::cell_t mem [DEPTH];
  pss_pkg::cell_t rdata;
  pss_pkg::cell_t mem_wdata;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  logic           mem_we;
  logic           mem_re;

  pss_pkg::cmd_t                      cmd_q;
  logic [pss_pkg::ROW_W-1:0]          wr_row_q;
  logic [pss_pkg::CHANNEL_W-1:0]      wr_ch_q;
  logic [pss_pkg::NOTE_W-1:0]         wr_note_q;
  logic [pss_pkg::INSTR_W-1:0]        wr_instr_q;
  pss_pkg::in_data_t                  in_data;

  logic [RW-1:0]                 cur_row;
  logic [RW-1:0]                 cur_row_next;
  logic [CW-1:0]                 cur_ch;
  logic [CW-1:0]                 cur_ch_next;
  logic                          play;
  logic                          play_next;
  logic [RW-1:0]                 play_row;
  logic [RW-1:0]                 play_row_next;
  logic [pss_pkg::TICK_W-1:0]    te;
  logic [pss_pkg::TICK_W-1:0]    te_next;
  logic [pss_pkg::TICK_W-1:0]    te_inc;
  logic [RW-1:0]                 scan_row;
  logic [RW-1:0]                 scan_row_next;
  logic [CW-1:0]                 scan_ch;
  logic [AW-1:0]                 clr_addr;
  logic                          silence_q;
  logic                          silence_next;
  logic                          open_q;
  logic                          open_next;
  logic                          need_scan;

  logic                          snd_on;
  logic [pss_pkg::PITCH_W-1:0]   snd_pitch;
  logic [pss_pkg::LEVEL_W-1:0]   snd_level;
  logic                          hit_noise;
  logic [pss_pkg::PITCH_W-1:0]   hit_pitch;
  logic [pss_pkg::LEVEL_W-1:0]   hit_level;

  logic [pss_pkg::NOTE_W-1:0]    edit_note;
  logic [8:0]                    wr_row_ext;
  logic [3:0]                    wr_ch_ext;
  logic                          wr_in_range;
  logic [pss_pkg::NOTE_W-1:0]    wr_note_sat;
  logic [8:0]                    play_row_ext;
  logic [8:0]                    cur_row_ext;
  logic [3:0]                    cur_ch_ext;

  pss_pkg::out_data_t            out_q;

  assign in_data = pss_pkg::in_data_t'(s_tdata);
  assign m_tdata = out_q;

  assign wr_row_ext   = 9'(wr_row_q);
  assign wr_ch_ext    = 4'(wr_ch_q);
  assign wr_in_range  = (wr_row_ext < 9'(ROWS)) && (wr_ch_ext < 4'(CHANNELS));
  assign wr_note_sat  = (wr_note_q > pss_pkg::NOTE_MAX) ? pss_pkg::NOTE_MAX : wr_note_q;
  assign play_row_ext = 9'(play_row);
  assign cur_row_ext  = 9'(cur_row);
  assign cur_ch_ext   = 4'(cur_ch);
  assign te_inc       = (te != pss_pkg::TICK_SAT) ? te + 8'd1 : te;

  always_comb begin
    if (rdata.note == '0) begin
      edit_note = 5'd1;
    end else if (cmd_q == pss_pkg::CMD_NOTE_DOWN && rdata.note > 5'd1) begin
      edit_note = rdata.note - 5'd1;
    end else if (cmd_q == pss_pkg::CMD_NOTE_UP && rdata.note < pss_pkg::NOTE_MAX) begin
      edit_note = rdata.note + 5'd1;
    end else begin
      edit_note = rdata.note;
    end
  end

  assign hit_noise = (4'(scan_ch) == 4'(pss_pkg::NOISE_CHANNEL));
  assign hit_pitch = hit_noise
                   ? pss_pkg::NOISE_PITCH_BASE + 7'(pss_pkg::note_mod12(rdata.note))
                   : pss_pkg::TONE_PITCH_BASE + 7'(rdata.note);
  assign hit_level = hit_noise ? pss_pkg::NOISE_LEVEL : pss_pkg::TONE_LEVEL;

  assign sts.clr_last  = &clr_addr;
  assign sts.need_scan = need_scan;
  assign sts.scan_hit  = (rdata.note != '0);
  assign sts.scan_last = (scan_ch == LAST_CH);

  always_comb begin
    mem_re = ctl.take || ctl.scan_rd || ctl.fin_rd;
    if (ctl.scan_rd) begin
      mem_raddr = {scan_row, scan_ch};
    end else begin
      mem_raddr = {cur_row, cur_ch};
    end
  end

  always_comb begin
    cur_row_next  = cur_row;
    cur_ch_next   = cur_ch;
    play_next     = play;
    play_row_next = play_row;
    te_next       = te;
    scan_row_next = scan_row;
    silence_next  = 1'b0;
    open_next     = 1'b0;
    need_scan     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = {cur_row, cur_ch};
    mem_wdata     = rdata;
    if (ctl.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (ctl.exec) begin
      unique case (cmd_q) inside
        pss_pkg::CMD_TICK: begin
          if (play) begin
            if (te_inc >= ticks_per_row) begin
              te_next       = '0;
              play_row_next = (play_row == LAST_ROW) ? '0 : play_row + 1'b1;
              scan_row_next = play_row_next;
              need_scan     = 1'b1;
            end else begin
              te_next = te_inc;
            end
          end
        end
        pss_pkg::CMD_UP: begin
          if (cur_row != '0) begin
            cur_row_next = cur_row - 1'b1;
          end
        end
        pss_pkg::CMD_DOWN: begin
          if (cur_row != LAST_ROW) begin
            cur_row_next = cur_row + 1'b1;
          end
        end
        pss_pkg::CMD_LEFT: begin
          if (cur_ch != '0) begin
            cur_ch_next = cur_ch - 1'b1;
          end
        end
        pss_pkg::CMD_RIGHT: begin
          if (cur_ch != LAST_CH) begin
            cur_ch_next = cur_ch + 1'b1;
          end
        end
        pss_pkg::CMD_NOTE_DOWN, pss_pkg::CMD_NOTE_UP: begin
          mem_we         = 1'b1;
          mem_wdata.note = edit_note;
          open_next      = 1'b1;
          scan_row_next  = cur_row;
          need_scan      = 1'b1;
        end
        pss_pkg::CMD_NEXT_INSTR: begin
          if (rdata.note != '0) begin
            mem_we               = 1'b1;
            mem_wdata.instrument = rdata.instrument + 1'b1;
          end
        end
        pss_pkg::CMD_CLEAR: begin
          mem_we    = 1'b1;
          mem_wdata = '0;
        end
        pss_pkg::CMD_PLAY_TOGGLE: begin
          if (play) begin
            play_next    = 1'b0;
            silence_next = 1'b1;
          end else begin
            play_next     = 1'b1;
            open_next     = 1'b1;
            play_row_next = LAST_ROW;
            te_next       = pss_pkg::TICK_SAT;
          end
        end
        pss_pkg::CMD_WRITE_CELL: begin
          if (wr_in_range) begin
            mem_we               = 1'b1;
            mem_waddr            = {wr_row_ext[RW-1:0], wr_ch_ext[CW-1:0]};
            mem_wdata.note       = wr_note_sat;
            mem_wdata.instrument = wr_instr_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row  <= '0;
      cur_ch   <= '0;
      play     <= 1'b0;
      play_row <= '0;
      te       <= '0;
      clr_addr <= '0;
    end else begin
      if (ctl.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (ctl.exec) begin
        cur_row  <= cur_row_next;
        cur_ch   <= cur_ch_next;
        play     <= play_next;
        play_row <= play_row_next;
        te       <= te_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      cmd_q      <= pss_pkg::cmd_t'(s_tuser);
      wr_row_q   <= in_data.row;
      wr_ch_q    <= in_data.channel;
      wr_note_q  <= in_data.note;
      wr_instr_q <= in_data.instrument;
    end
    if (ctl.exec) begin
      scan_row  <= scan_row_next;
      scan_ch   <= '0;
      snd_on    <= 1'b0;
      snd_pitch <= '0;
      snd_level <= '0;
      silence_q <= silence_next;
      open_q    <= open_next;
    end
    if (ctl.scan_chk) begin
      if (sts.scan_hit) begin
        snd_on    <= 1'b1;
        snd_pitch <= hit_pitch;
        snd_level <= hit_level;
      end else begin
        scan_ch <= scan_ch + 1'b1;
      end
    end
    if (ctl.fin_load) begin
      out_q.pad             <= '0;
      out_q.cell_instrument <= rdata.instrument;
      out_q.cell_note       <= rdata.note;
      out_q.cursor_channel  <= cur_ch_ext[pss_pkg::CHANNEL_W-1:0];
      out_q.cursor_row      <= cur_row_ext[pss_pkg::ROW_W-1:0];
      out_q.play_row        <= play_row_ext[pss_pkg::ROW_W-1:0];
      out_q.playing         <= play;
      out_q.open_channel    <= open_q;
      out_q.silence         <= silence_q;
      out_q.level           <= snd_level;
      out_q.pitch           <= snd_pitch;
      out_q.note_on         <= snd_on;
    end
  end

endmodule

// ===== src/pattern_step_sequencer.sv =====
// Top level of the pattern step sequencer: register port, controller and datapath.
//
// Tracker-style pattern sequencer. After reset the pattern memory is swept to
// zero, one entry a cycle, over 2^ceil(log2(ROWS)) * 2^max(1, ceil(log2(CHANNELS)))
// entries (128 with the default 32 x 4 pattern); s_tready stays low until the sweep
// ends, while register writes are taken at any time. Each item then steps through
// the controller: accept, execute, on a playback step or a note edit a read and a
// check per channel until the first note of the row or the last channel, then a
// read of the cell under the cursor and a load of the result register, which waits
// while an earlier result is not yet taken. The single pattern memory read port
// serialises these reads. The result sits in an output register, so the next item
// is taken while a result still waits on m_tready.
module pattern_step_sequencer #(
  parameter int ROWS     = pss_pkg::ROWS_DEFAULT,
  parameter int CHANNELS = pss_pkg::CHANNELS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // row[4:0], channel[6:5], note[11:7], instrument[13:12], zero[15:14]
  input  logic [pss_pkg::IN_DATA_W-1:0]      s_tdata,
  // command[3:0]
  input  logic [pss_pkg::COMMAND_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // note_on[0], pitch[7:1], level[10:8], silence[11], open_channel[12],
  // playing[13], play_row[18:14], cursor_row[23:19], cursor_channel[25:24],
  // cell_note[30:26], cell_instrument[32:31], zero[39:33]
  output logic [pss_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pss_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

`include "pattern_step_sequencer_macros.svh"

  logic [pss_pkg::TICK_W-1:0] ticks_per_row;
  pss_pkg::dp_ctl_t           ctl;
  pss_pkg::dp_sts_t           sts;

  assign pready = 1'b1;
  assign prdata = (paddr == pss_pkg::ADDR_TICKS_PER_ROW)
                ? pss_pkg::APB_DATA_W'(ticks_per_row) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_row <= pss_pkg::TICKS_PER_ROW_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == pss_pkg::ADDR_TICKS_PER_ROW) begin
      ticks_per_row <= pwdata[pss_pkg::TICK_W-1:0];
    end
  end

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctl      (ctl),
    .sts      (sts)
  );

  pss_datapath #(
    .ROWS     (ROWS),
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .ticks_per_row (ticks_per_row),
    .m_tdata       (m_tdata)
  );

  `PSS_ASSERT_ALWAYS(a_sweep_after_reset, rst |=> (!s_tready && !m_tvalid))
  `PSS_ASSERT(a_one_item_in_flight, (s_tvalid && s_tready) |=> !s_tready)
  `PSS_ASSERT(a_no_result_overwrite, ctl.fin_load |-> (!m_tvalid || m_tready))
  `PSS_ASSERT(a_scan_only_while_busy, (ctl.scan_rd || ctl.scan_chk) |-> !s_tready)

endmodule

// ===== tb/pattern_step_sequencer_tb.sv =====
// Testbench for the pattern step sequencer: directed and random edit and playback commands.
module pattern_step_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS           = pss_pkg::ROWS_DEFAULT;
  localparam int CHANNELS       = pss_pkg::CHANNELS_DEFAULT;
  localparam int CELLS          = ROWS * CHANNELS;
  localparam int RESET_CYCLES   = 6;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 250;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;
  localparam logic [pss_pkg::COMMAND_W-1:0] CMD_CODE_TOP = '1;

  class sequencer_scoreboard;
    logic [pss_pkg::NOTE_W-1:0]    notes[CELLS];
    logic [pss_pkg::INSTR_W-1:0]   instrs[CELLS];
    logic [pss_pkg::ROW_W-1:0]     cur_row;
    logic [pss_pkg::CHANNEL_W-1:0] cur_ch;
    logic                          playing;
    logic [pss_pkg::ROW_W-1:0]     play_row;
    logic [pss_pkg::TICK_W-1:0]    elapsed;
    logic [pss_pkg::TICK_W-1:0]    ticks_per_row;
    pss_pkg::out_data_t            status_q[$];
    int                            error_count;

    function new();
      foreach (notes[i]) begin
        notes[i]  = '0;
        instrs[i] = '0;
      end
      cur_row       = '0;
      cur_ch        = '0;
      playing       = 1'b0;
      play_row      = '0;
      elapsed       = '0;
      ticks_per_row = pss_pkg::TICKS_PER_ROW_RESET;
      error_count   = 0;
    endfunction

    function int cell_index(logic [pss_pkg::ROW_W-1:0] r, logic [pss_pkg::CHANNEL_W-1:0] c);
      return (int'(r) * CHANNELS + int'(c)) % CELLS;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void set_ticks_per_row(logic [pss_pkg::TICK_W-1:0] value);
      ticks_per_row = value;
    endfunction

    // Sound the first channel of row r that holds a note.
    function void sound_row(input logic [pss_pkg::ROW_W-1:0] r,
                            inout pss_pkg::out_data_t s);
      logic [pss_pkg::NOTE_W-1:0] n;
      for (int c = 0; c < CHANNELS; c++) begin
        n = notes[cell_index(r, pss_pkg::CHANNEL_W'(c))];
        if (n != 0) begin
          s.note_on = 1'b1;
          if (c == pss_pkg::NOISE_CHANNEL) begin
            s.pitch = pss_pkg::NOISE_PITCH_BASE
                    + pss_pkg::PITCH_W'(n % pss_pkg::NOTE_OCTAVE);
            s.level = pss_pkg::NOISE_LEVEL;
          end else begin
            s.pitch = pss_pkg::TONE_PITCH_BASE + pss_pkg::PITCH_W'(n);
            s.level = pss_pkg::TONE_LEVEL;
          end
          return;
        end
      end
    endfunction

    function void note_command(logic [pss_pkg::COMMAND_W-1:0] cmd, pss_pkg::in_data_t d);
      pss_pkg::out_data_t s;
      int                 slot;
      s    = '0;
      slot = cell_index(cur_row, cur_ch);
      case (cmd) inside
        pss_pkg::CMD_TICK: begin
          if (playing) begin
            if (elapsed != pss_pkg::TICK_SAT) elapsed++;
            if (elapsed >= ticks_per_row) begin
              elapsed  = '0;
              play_row = (play_row == pss_pkg::ROW_W'(ROWS - 1)) ? '0 : play_row + 1'b1;
              sound_row(play_row, s);
            end
          end
        end
        pss_pkg::CMD_UP:    if (cur_row > 0) cur_row--;
        pss_pkg::CMD_DOWN:  if (cur_row < pss_pkg::ROW_W'(ROWS - 1)) cur_row++;
        pss_pkg::CMD_LEFT:  if (cur_ch > 0) cur_ch--;
        pss_pkg::CMD_RIGHT: if (cur_ch < pss_pkg::CHANNEL_W'(CHANNELS - 1)) cur_ch++;
        pss_pkg::CMD_NOTE_DOWN, pss_pkg::CMD_NOTE_UP: begin
          if (notes[slot] == 0) notes[slot] = pss_pkg::NOTE_W'(1);
          else if (cmd == pss_pkg::CMD_NOTE_DOWN && notes[slot] > 1) notes[slot]--;
          else if (cmd == pss_pkg::CMD_NOTE_UP && notes[slot] < pss_pkg::NOTE_MAX)
            notes[slot]++;
          s.open_channel = 1'b1;
          sound_row(cur_row, s);
        end
        pss_pkg::CMD_NEXT_INSTR: if (notes[slot] != 0) instrs[slot] = instrs[slot] + 1'b1;
        pss_pkg::CMD_CLEAR: begin
          notes[slot]  = '0;
          instrs[slot] = '0;
        end
        pss_pkg::CMD_PLAY_TOGGLE: begin
          if (playing) begin
            playing   = 1'b0;
            s.silence = 1'b1;
          end else begin
            s.open_channel = 1'b1;
            playing        = 1'b1;
            play_row       = pss_pkg::ROW_W'(ROWS - 1);
            elapsed        = pss_pkg::TICK_SAT;
          end
        end
        pss_pkg::CMD_WRITE_CELL: begin
          if (int'(d.row) < ROWS && int'(d.channel) < CHANNELS) begin
            slot         = cell_index(d.row, d.channel);
            notes[slot]  = (d.note > pss_pkg::NOTE_MAX) ? pss_pkg::NOTE_MAX : d.note;
            instrs[slot] = d.instrument;
          end
        end
        default: ;
      endcase
      slot              = cell_index(cur_row, cur_ch);
      s.playing         = playing;
      s.play_row        = play_row;
      s.cursor_row      = cur_row;
      s.cursor_channel  = cur_ch;
      s.cell_note       = notes[slot];
      s.cell_instrument = instrs[slot];
      status_q.push_back(s);
    endfunction

    function string show(pss_pkg::out_data_t s);
      return $sformatf({"on=%0d pitch=%0d level=%0d silence=%0d open=%0d playing=%0d ",
                        "play_row=%0d cursor=%0d/%0d cell=%0d/%0d"},
                       s.note_on, s.pitch, s.level, s.silence, s.open_channel, s.playing,
                       s.play_row, s.cursor_row, s.cursor_channel, s.cell_note,
                       s.cell_instrument);
    endfunction

    function void flag(string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    function void check_status(logic [pss_pkg::OUT_DATA_W-1:0] raw);
      pss_pkg::out_data_t got;
      pss_pkg::out_data_t want;
      got = raw;
      if (status_q.size() == 0) begin
        flag({"unexpected result ", show(got)});
        return;
      end
      want = status_q.pop_front();
      if (got.note_on !== want.note_on || got.pitch !== want.pitch ||
          got.level !== want.level || got.silence !== want.silence ||
          got.open_channel !== want.open_channel || got.playing !== want.playing ||
          got.play_row !== want.play_row || got.cursor_row !== want.cursor_row ||
          got.cursor_channel !== want.cursor_channel || got.cell_note !== want.cell_note ||
          got.cell_instrument !== want.cell_instrument)
        flag({"expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic                               clk      = 1'b0;
  logic                               rst      = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [pss_pkg::IN_DATA_W-1:0]      s_tdata  = '0;
  logic [pss_pkg::COMMAND_W-1:0]      s_tuser  = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [pss_pkg::OUT_DATA_W-1:0]     m_tdata;
  logic                               psel     = 1'b0;
  logic                               penable  = 1'b0;
  logic                               pwrite   = 1'b0;
  logic [pss_pkg::APB_ADDR_W-1:0]     paddr    = '0;
  logic [pss_pkg::APB_DATA_W-1:0]     pwdata   = '0;
  logic [pss_pkg::APB_DATA_W-1:0]     prdata;
  logic                               pready;

  sequencer_scoreboard board;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   down_bias     = 50;
  logic hold_go       = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;

  int                         phase_send_idle[PHASES] = '{0, 79, 0, 17, 0};
  int                         phase_stall[PHASES]     = '{0, 0, 79, 17, 0};
  int                         phase_down_bias[PHASES] = '{50, 85, 85, 10, 10};
  logic [pss_pkg::TICK_W-1:0] phase_ticks[PHASES]     = '{8'd0, 8'd255, 8'd3, 8'd1, 8'd7};

  pattern_step_sequencer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Take results, stall at random or hold off for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) board.check_status(m_tdata);
      if (hold_go != hold_seen) begin
        hold_seen <= hold_go;
        hold_left <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [pss_pkg::APB_ADDR_W-1:0] addr,
                           input logic [pss_pkg::TICK_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= pss_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_ticks_per_row(value);
  endtask

  task automatic send_item(input logic [pss_pkg::COMMAND_W-1:0] cmd,
                           input pss_pkg::in_data_t d);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_command(cmd, d);
  endtask

  function automatic pss_pkg::in_data_t make_cell(int r, int c, int n, int ins);
    pss_pkg::in_data_t d;
    d            = '0;
    d.row        = pss_pkg::ROW_W'(r);
    d.channel    = pss_pkg::CHANNEL_W'(c);
    d.note       = pss_pkg::NOTE_W'(n);
    d.instrument = pss_pkg::INSTR_W'(ins);
    return d;
  endfunction

  function automatic void pick_item(output logic [pss_pkg::COMMAND_W-1:0] cmd,
                                    output pss_pkg::in_data_t d);
    int r;
    r = $urandom_range(99);
    d = make_cell($urandom_range(ROWS - 1), $urandom_range(CHANNELS - 1),
                  $urandom_range(pss_pkg::NOTE_MAX), $urandom_range(3));
    if (r < 38)      cmd = pss_pkg::CMD_TICK;
    else if (r < 50) cmd = ($urandom_range(99) < down_bias) ? pss_pkg::CMD_DOWN : pss_pkg::CMD_UP;
    else if (r < 57) cmd = $urandom_range(1) ? pss_pkg::CMD_RIGHT : pss_pkg::CMD_LEFT;
    else if (r < 66) cmd = $urandom_range(1) ? pss_pkg::CMD_NOTE_UP : pss_pkg::CMD_NOTE_DOWN;
    else if (r < 71) cmd = pss_pkg::CMD_NEXT_INSTR;
    else if (r < 74) cmd = pss_pkg::CMD_CLEAR;
    else if (r < 77) cmd = pss_pkg::CMD_PLAY_TOGGLE;
    else if (r < 93) begin
      cmd = pss_pkg::CMD_WRITE_CELL;
      if ($urandom_range(3) == 0) begin
        d.row     = board.cur_row;
        d.channel = board.cur_ch;
      end
      if ($urandom_range(99) < 15) begin
        d.note = pss_pkg::NOTE_W'($urandom_range(pss_pkg::NOTE_MAX + 1, 31));
      end else if ($urandom_range(99) < 8) begin
        d.note = '0;
      end
    end else begin
      cmd = pss_pkg::COMMAND_W'($urandom_range(pss_pkg::CMD_NONE, CMD_CODE_TOP));
    end
  endfunction

  initial begin
    logic [pss_pkg::COMMAND_W-1:0] cmd;
    pss_pkg::in_data_t             d;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    apb_write(pss_pkg::ADDR_TICKS_PER_ROW, 8'd1);

    send_item(pss_pkg::CMD_UP, '0);
    send_item(pss_pkg::CMD_LEFT, '0);
    send_item(pss_pkg::CMD_NEXT_INSTR, '0);
    send_item(pss_pkg::CMD_NOTE_DOWN, '0);
    send_item(pss_pkg::CMD_NOTE_DOWN, '0);
    send_item(pss_pkg::CMD_NEXT_INSTR, '0);
    send_item(pss_pkg::CMD_WRITE_CELL, make_cell(0, 0, 31, 3));
    send_item(pss_pkg::CMD_NOTE_UP, '0);
    send_item(pss_pkg::CMD_CLEAR, '0);
    send_item(pss_pkg::CMD_NOTE_UP, '0);
    send_item(pss_pkg::CMD_WRITE_CELL, make_cell(0, 3, 23, 2));
    send_item(pss_pkg::CMD_WRITE_CELL, make_cell(0, 0, 0, 1));
    send_item(pss_pkg::CMD_TICK, '0);
    send_item(pss_pkg::CMD_PLAY_TOGGLE, '0);
    send_item(pss_pkg::CMD_TICK, '0);
    send_item(pss_pkg::CMD_TICK, '0);
    send_item(pss_pkg::CMD_WRITE_CELL, make_cell(ROWS - 1, CHANNELS - 1, 31, 3));
    repeat (CHANNELS) send_item(pss_pkg::CMD_RIGHT, '0);
    send_item(pss_pkg::CMD_NONE, '0);
    send_item(CMD_CODE_TOP, '0);
    send_item(pss_pkg::CMD_PLAY_TOGGLE, '0);
    send_item(pss_pkg::CMD_DOWN, '0);
    s_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      while (board.pending() != 0) @(posedge clk);
      apb_write(pss_pkg::ADDR_TICKS_PER_ROW, phase_ticks[p]);
      send_idle_pct = phase_send_idle[p];
      stall_pct     = phase_stall[p];
      down_bias     = phase_down_bias[p];
      if (p == 0) hold_go <= ~hold_go;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick_item(cmd, d);
        send_item(cmd, d);
      end
      s_tvalid <= 1'b0;
    end

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.error_count == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
